// File: rtl/core/u8dec_pkg.sv
// Package for the UTF-8 validating decoder: request types, status and
// command codes, and the lead byte classifier.
// No dependencies.
package u8dec_pkg;

  // Command codes on the input request
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ILL_FORMED = 2'd1;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

  // Continuation byte limits
  localparam logic [7:0] CONT_LOW_DEF  = 8'h80;
  localparam logic [7:0] CONT_HIGH_DEF = 8'hBF;

  // Result queue depth (must hold two results from one request plus slack)
  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  status;
    logic [2:0]  byte_count;
    logic        last_of_run;
  } out_req_t;

  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_BAD,
    LEAD_OPEN
  } lead_kind_e;

  typedef struct packed {
    lead_kind_e  kind;
    logic [1:0]  need;
    logic [20:0] acc;
    logic [7:0]  low;
    logic [7:0]  high;
  } lead_t;

  // Classify a byte seen with no sequence pending
  function automatic lead_t lead_f(input logic [7:0] b);
    lead_t r;
    r.kind = LEAD_OPEN;
    r.need = 2'd0;
    r.acc  = '0;
    r.low  = CONT_LOW_DEF;
    r.high = CONT_HIGH_DEF;
    if (b inside {[8'h00:8'h7F]}) begin
      r.kind = LEAD_ASCII;
    end else if (!(b inside {[8'hC2:8'hF4]})) begin
      r.kind = LEAD_BAD;
    end else if (b inside {[8'hC2:8'hDF]}) begin
      r.need = 2'd1;
      r.acc  = {10'd0, b[4:0], 6'd0};
    end else if (b inside {[8'hE0:8'hEF]}) begin
      r.need = 2'd2;
      r.acc  = {5'd0, b[3:0], 12'd0};
      if (b == 8'hE0) r.low  = 8'hA0;
      if (b == 8'hED) r.high = 8'h9F;
    end else begin
      r.need = 2'd3;
      r.acc  = {b[2:0], 18'd0};
      if (b == 8'hF0) r.low  = 8'h90;
      if (b == 8'hF4) r.high = 8'h8F;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/utf8_validating_decoder.sv
// Top level of the UTF-8 validating decoder: sequence state, decode logic
// and a small result queue. Depends on u8dec_pkg.

// Takes one request per cycle while in_stall_o is low: a data byte or an end-of-string marker.
// Each request is decoded in the cycle it is accepted and its results (zero,
// one or two) go into a four-entry result queue, so the input keeps flowing
// while the output side stalls. The input stalls whenever fewer than two
// queue slots are free. A byte that breaks a sequence and is itself a
// complete or bad lead gives two results; every other request gives at
// most one. Ill-formed results carry the byte count of the broken prefix;
// end of string inside a sequence gives one incomplete result; end of
// string while idle gives none.
module utf8_validating_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  u8dec_pkg::in_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output u8dec_pkg::out_req_t out_req_o
);
  import u8dec_pkg::*;

  localparam int unsigned PtrW = $clog2(RES_DEPTH);
  localparam int unsigned CntW = $clog2(RES_DEPTH + 1);

  // Sequence state
  logic [20:0] acc_q, acc_d;
  logic [1:0]  need_q, need_d;
  logic [2:0]  taken_q, taken_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  high_q, high_d;

  // Result queue
  out_req_t            res_q [RES_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  logic     in_acc, out_acc;
  out_req_t res0, res1;
  logic [1:0] n_res;
  lead_t    lead;
  logic [20:0] acc_ext;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Decode one request against the current sequence state
  always_comb begin
    lead    = lead_f(in_req_i.data_byte);
    acc_d   = acc_q;
    need_d  = need_q;
    taken_d = taken_q;
    low_d   = low_q;
    high_d  = high_q;
    res0    = '0;
    res1    = '0;
    n_res   = 2'd0;
    acc_ext = acc_q;
    case (need_q)
      2'd1:    acc_ext = acc_q | {15'd0, in_req_i.data_byte[5:0]};
      2'd2:    acc_ext = acc_q | {9'd0, in_req_i.data_byte[5:0], 6'd0};
      2'd3:    acc_ext = acc_q | {3'd0, in_req_i.data_byte[5:0], 12'd0};
      default: acc_ext = acc_q;
    endcase

    if (in_req_i.cmd == CMD_EOS) begin
      if (need_q != 2'd0) begin
        res0  = '{code_point: '0, status: STATUS_INCOMPLETE, byte_count: 3'd0,
                  last_of_run: 1'b1};
        n_res = 2'd1;
      end
      acc_d = '0; need_d = '0; taken_d = '0;
      low_d = CONT_LOW_DEF; high_d = CONT_HIGH_DEF;
    end else if (need_q == 2'd0) begin
      case (lead.kind)
        LEAD_ASCII: begin
          res0  = '{code_point: {13'd0, in_req_i.data_byte}, status: STATUS_OK,
                    byte_count: 3'd1, last_of_run: 1'b1};
          n_res = 2'd1;
        end
        LEAD_BAD: begin
          res0  = '{code_point: '0, status: STATUS_ILL_FORMED, byte_count: 3'd1,
                    last_of_run: 1'b1};
          n_res = 2'd1;
        end
        default: begin
          acc_d = lead.acc; need_d = lead.need; taken_d = 3'd1;
          low_d = lead.low; high_d = lead.high;
        end
      endcase
    end else if (in_req_i.data_byte >= low_q && in_req_i.data_byte <= high_q) begin
      // Valid continuation
      acc_d   = acc_ext;
      need_d  = need_q - 2'd1;
      taken_d = taken_q + 3'd1;
      low_d   = CONT_LOW_DEF;
      high_d  = CONT_HIGH_DEF;
      if (need_q == 2'd1) begin
        res0  = '{code_point: acc_ext, status: STATUS_OK, byte_count: taken_q + 3'd1,
                  last_of_run: 1'b1};
        n_res = 2'd1;
        acc_d = '0; taken_d = '0;
      end
    end else begin
      // Broken sequence: report the prefix, then treat the byte as a lead
      res0  = '{code_point: '0, status: STATUS_ILL_FORMED, byte_count: taken_q,
                last_of_run: 1'b0};
      acc_d = '0; need_d = '0; taken_d = '0;
      low_d = CONT_LOW_DEF; high_d = CONT_HIGH_DEF;
      case (lead.kind)
        LEAD_ASCII: begin
          res1  = '{code_point: {13'd0, in_req_i.data_byte}, status: STATUS_OK,
                    byte_count: 3'd1, last_of_run: 1'b1};
          n_res = 2'd2;
        end
        LEAD_BAD: begin
          res1  = '{code_point: '0, status: STATUS_ILL_FORMED, byte_count: 3'd1,
                    last_of_run: 1'b1};
          n_res = 2'd2;
        end
        default: begin
          res0.last_of_run = 1'b1;
          n_res = 2'd1;
          acc_d = lead.acc; need_d = lead.need; taken_d = 3'd1;
          low_d = lead.low; high_d = lead.high;
        end
      endcase
    end
  end

  // Sequence state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      need_q  <= '0;
      taken_q <= '0;
      low_q   <= CONT_LOW_DEF;
      high_q  <= CONT_HIGH_DEF;
    end else if (in_acc) begin
      acc_q   <= acc_d;
      need_q  <= need_d;
      taken_q <= taken_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      res_q[wr_ptr_q] <= res0;
      if (n_res == 2'd2) begin
        res_q[wr_ptr_q + PtrW'(1)] <= res1;
      end
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (in_acc ? CntW'(n_res) : CntW'(0)) - (out_acc ? CntW'(1) : CntW'(0));
    end
  end

  assign in_stall_o  = cnt_q > CntW'(RES_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_req_o   = res_q[rd_ptr_q];

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RES_DEPTH))
    else $error("result queue overflow");

  // The partner of a non-final result is already queued behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.last_of_run |-> cnt_q >= CntW'(2))
    else $error("non-final result without its partner");

  // End of string always leaves the decoder idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_i.cmd == CMD_EOS |=> need_q == 2'd0)
    else $error("sequence pending after end of string");

  // No bytes counted while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q == 2'd0 |-> taken_q == 3'd0)
    else $error("byte count held while idle");

endmodule

// File: bench/utf8_validating_decoder_tb.sv
// Self-checking testbench for utf8_validating_decoder: directed and random
// byte streams, with an in-bench UTF-8 decoder that predicts every result.
// Depends on u8dec_pkg and the decoder RTL.
module utf8_validating_decoder_tb;
  import u8dec_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned IDLE_PERCENT  = 27;
  localparam int unsigned MAX_PRINTED   = 40;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  // Idling switches for each side
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  // Decoder state mirrored by the bench
  logic [20:0] seq_acc;
  logic [1:0]  seq_need;
  logic [2:0]  seq_taken;
  logic [7:0]  cont_lo;
  logic [7:0]  cont_hi;

  out_req_t decoded_q[$];   // results still owed by the DUT, oldest first
  out_req_t run_q[$];       // results caused by the request being decoded

  int unsigned cycle_cnt = 0;
  int unsigned n_items = 0;
  int unsigned n_errors = 0;
  int unsigned n_ok = 0;
  int unsigned n_ill = 0;
  int unsigned n_incomplete = 0;
  int unsigned n_double = 0;

  // Result sampled before the edge at which it is taken
  bit       res_take = 1'b0;
  out_req_t res_got;

  utf8_validating_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               decoded_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void emit(logic [20:0] cp, logic [1:0] st, logic [2:0] cnt);
    out_req_t r;
    r.code_point  = cp;
    r.status      = st;
    r.byte_count  = cnt;
    r.last_of_run = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void clear_seq();
    seq_acc   = '0;
    seq_need  = '0;
    seq_taken = '0;
    cont_lo   = CONT_LOW_DEF;
    cont_hi   = CONT_HIGH_DEF;
  endfunction

  // Byte seen with no sequence open: ASCII, bad lead, or start of a sequence
  function automatic void start_seq(logic [7:0] b);
    if (b <= 8'h7F) begin
      emit({13'd0, b}, STATUS_OK, 3'd1);
    end else if (b < 8'hC2 || b > 8'hF4) begin
      emit('0, STATUS_ILL_FORMED, 3'd1);
    end else begin
      cont_lo   = CONT_LOW_DEF;
      cont_hi   = CONT_HIGH_DEF;
      seq_taken = 3'd1;
      if (b <= 8'hDF) begin
        seq_need = 2'd1;
        seq_acc  = 21'(b[4:0]) << 6;
      end else if (b <= 8'hEF) begin
        seq_need = 2'd2;
        seq_acc  = 21'(b[3:0]) << 12;
        if (b == 8'hE0) cont_lo = 8'hA0;
        if (b == 8'hED) cont_hi = 8'h9F;
      end else begin
        seq_need = 2'd3;
        seq_acc  = 21'(b[2:0]) << 18;
        if (b == 8'hF0) cont_lo = 8'h90;
        if (b == 8'hF4) cont_hi = 8'h8F;
      end
    end
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic void decode_byte(in_req_t r);
    logic [7:0] b;
    int         sh;
    b = r.data_byte;
    run_q.delete();
    if (r.cmd == CMD_EOS) begin
      if (seq_need != 2'd0) emit('0, STATUS_INCOMPLETE, 3'd0);
      clear_seq();
    end else if (seq_need == 2'd0) begin
      start_seq(b);
    end else if (b >= cont_lo && b <= cont_hi) begin
      sh        = 6 * (int'(seq_need) - 1);
      seq_acc   = seq_acc | (21'(b[5:0]) << sh);
      seq_need  = seq_need - 2'd1;
      seq_taken = seq_taken + 3'd1;
      cont_lo   = CONT_LOW_DEF;
      cont_hi   = CONT_HIGH_DEF;
      if (seq_need == 2'd0) begin
        emit(seq_acc, STATUS_OK, seq_taken);
        clear_seq();
      end
    end else begin
      // broken prefix reported, then the byte is taken as a new lead
      emit('0, STATUS_ILL_FORMED, seq_taken);
      clear_seq();
      start_seq(b);
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    if (run_q.size() > 1) n_double++;
    foreach (run_q[i]) decoded_q.push_back(run_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    n_errors++;
    if (n_errors <= MAX_PRINTED) begin
      $display("cycle %0d: %s mismatch, got 0x%0h expected 0x%0h", cycle_cnt, what,
               got, want);
    end
  endtask

  task automatic check_result(out_req_t got);
    out_req_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("unexpected result, code_point", 32'(got.code_point), 0);
      return;
    end
    want = decoded_q.pop_front();
    if (got.code_point !== want.code_point)
      report_mismatch("code_point", 32'(got.code_point), 32'(want.code_point));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.byte_count !== want.byte_count)
      report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    case (want.status)
      STATUS_OK:         n_ok++;
      STATUS_ILL_FORMED: n_ill++;
      default:           n_incomplete++;
    endcase
  endtask

  // Output side: sample away from the edge, check at the edge that takes it
  always @(negedge clk_i) begin
    res_take <= rst_ni && out_valid && !out_stall;
    res_got  <= out_req;
  end

  always @(posedge clk_i) begin
    if (res_take) check_result(res_got);
  end

  // Output stall pattern
  always @(posedge clk_i) begin
    out_stall <= out_idle_on && ($urandom_range(99) < IDLE_PERCENT);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Send one request; returns at the edge where it was accepted
  task automatic send_item(input logic cmd, input logic [7:0] b);
    in_req_t req;
    logic    stalled;
    req.cmd       = cmd;
    req.data_byte = b;
    while (in_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    forever begin
      @(negedge clk_i);
      stalled = in_stall;
      if (!stalled) decode_byte(req);
      @(posedge clk_i);
      if (!stalled) break;
    end
    n_items++;
  endtask

  // Hold off the sender until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_item(CMD_DATA, bytes[i]);
  endtask

  // One character, usually well formed, sometimes truncated, corrupted or noise, or an end of string
  task automatic send_random_char();
    logic [7:0] seq [4];
    int         len;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(CMD_EOS, 8'($urandom));
      return;
    end
    if (pick < 16) begin
      send_item(CMD_DATA, 8'($urandom));
      return;
    end
    for (int i = 1; i < 4; i++) seq[i] = 8'($urandom_range(8'hBF, 8'h80));
    case ($urandom_range(3))
      0: begin
        seq[0] = 8'($urandom_range(8'h7F, 8'h00));
        len    = 1;
      end
      1: begin
        seq[0] = 8'($urandom_range(8'hDF, 8'hC2));
        len    = 2;
      end
      2: begin
        seq[0] = 8'($urandom_range(8'hEF, 8'hE0));
        len    = 3;
        if (seq[0] == 8'hE0) seq[1] = 8'($urandom_range(8'hBF, 8'hA0));
        if (seq[0] == 8'hED) seq[1] = 8'($urandom_range(8'h9F, 8'h80));
      end
      default: begin
        seq[0] = 8'($urandom_range(8'hF4, 8'hF0));
        len    = 4;
        if (seq[0] == 8'hF0) seq[1] = 8'($urandom_range(8'hBF, 8'h90));
        if (seq[0] == 8'hF4) seq[1] = 8'($urandom_range(8'h8F, 8'h80));
      end
    endcase
    if (pick < 24 && len > 1) begin
      len = $urandom_range(len - 1, 1);
    end else if (pick < 34 && len > 1) begin
      seq[$urandom_range(len - 1, 1)] = 8'($urandom);
    end
    for (int i = 0; i < len; i++) send_item(CMD_DATA, seq[i]);
  endtask

  // ASCII extremes, the shortest scalar of each longer length and the largest scalar
  task automatic test_valid_sequences();
    send_bytes('{8'h00, 8'h7F});
    send_bytes('{8'hC2, 8'h80});
    send_bytes('{8'hE0, 8'hA0, 8'h80});
    send_bytes('{8'hF0, 8'h90, 8'h80, 8'h80});
    send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
    wait_drained();
  endtask

  // Stray continuation and a byte that never leads
  task automatic test_bad_leads();
    send_bytes('{8'h80, 8'hFF});
    wait_drained();
  endtask

  // Narrowed second byte violated, bad byte then re-read as a lead
  task automatic test_broken_sequences();
    send_bytes('{8'hE0, 8'h9F});
    send_bytes('{8'hF4, 8'h90});
    send_bytes('{8'hED, 8'hA0});
    // broken prefix whose breaking byte opens a new sequence
    send_bytes('{8'hC2, 8'hE2});
    wait_drained();
  endtask

  // End of string inside a sequence and while idle
  task automatic test_end_of_string();
    send_item(CMD_EOS, 8'hFF);
    send_item(CMD_EOS, 8'h00);
    wait_drained();
  endtask

  // Random streams: idling, then a stretch without any, then idling again
  task automatic test_random_streams();
    int unsigned start;
    start = n_items;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    while (n_items < start + RANDOM_ITEMS / 3) send_random_char();
    wait_drained();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    while (n_items < start + (RANDOM_ITEMS * 2) / 3) send_random_char();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    while (n_items < start + RANDOM_ITEMS) send_random_char();
    send_item(CMD_EOS, 8'($urandom));
  endtask

  initial begin
    clear_seq();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_valid_sequences();
    test_bad_leads();
    test_broken_sequences();
    test_end_of_string();
    test_random_streams();

    // let everything drain, then watch for stray results
    in_valid    <= 1'b0;
    out_idle_on = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests over %0d cycles; %0d of them gave two results.",
             n_items, cycle_cnt, n_double);
    $display("Checked %0d scalars, %0d ill-formed and %0d incomplete results.",
             n_ok, n_ill, n_incomplete);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/u8dec_pkg.sv
rtl/core/utf8_validating_decoder.sv
bench/utf8_validating_decoder_tb.sv
